FILE: rtl/pbh_pkg.sv
// Shared types, constants and helpers for the path bounds and hash block.
// Holds the control word layout, command codes, program addresses and saturation.
// No dependencies.
package pbh_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int COORD_WIDTH = 32;
   localparam int SUM_WIDTH   = WORD_WIDTH + 2;
   localparam int HASH_WIDTH  = 64;
   localparam int CODE_WIDTH  = 4;
   localparam int PC_WIDTH    = 6;
   localparam int WORD_COUNT  = 8;
   localparam int POINT_WORDS = 6;

   typedef logic [PC_WIDTH-1:0]   pc_type;
   typedef logic [CODE_WIDTH-1:0] code_type;

   localparam logic [HASH_WIDTH-1:0] GOLDEN_K  = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [HASH_WIDTH-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

   localparam code_type CMD_SET_WINDING = 4'd0;
   localparam code_type CMD_MOVE        = 4'd1;
   localparam code_type CMD_LINE        = 4'd2;
   localparam code_type CMD_QUAD        = 4'd3;
   localparam code_type CMD_BEZIER      = 4'd4;
   localparam code_type CMD_ARC_TO      = 4'd5;
   localparam code_type CMD_ARC         = 4'd6;
   localparam code_type CMD_RECT        = 4'd7;
   localparam code_type CMD_CIRCLE      = 4'd8;
   localparam code_type CMD_ELLIPSE     = 4'd9;
   localparam code_type CMD_CLOSE       = 4'd10;
   localparam code_type CMD_CLEAR       = 4'd11;

   localparam pc_type A_CODE    = pc_type'(0);
   localparam pc_type A_WIND    = pc_type'(1);
   localparam pc_type A_NOWORDS = pc_type'(2);
   localparam pc_type A_LINE    = pc_type'(3);
   localparam pc_type A_QUAD    = pc_type'(5);
   localparam pc_type A_BEZIER  = pc_type'(9);
   localparam pc_type A_ARC_TO  = pc_type'(15);
   localparam pc_type A_ARC     = pc_type'(20);
   localparam pc_type A_RECT    = pc_type'(26);
   localparam pc_type A_CIRCLE  = pc_type'(34);
   localparam pc_type A_ELLIPSE = pc_type'(37);
   localparam pc_type A_CLEAR   = pc_type'(41);
   localparam pc_type A_NOP     = pc_type'(42);

   typedef enum logic [1:0] {
      HS_NONE,
      HS_CODE,
      HS_WIND,
      HS_WORD
   } hash_src_type;

   typedef enum logic [2:0] {
      PT_NONE,
      PT_W01,
      PT_W23,
      PT_W45,
      PT_CLO,
      PT_CHI,
      PT_SUM,
      PT_ELO
   } pt_op_type;

   typedef enum logic [1:0] {
      NX_SEQ,
      NX_BODY,
      NX_DONE
   } next_type;

   typedef struct packed {
      hash_src_type hash_src;
      logic [2:0]   word_sel;
      pt_op_type    pt_op;
      logic         mark;
      logic         clear;
      next_type     next;
   } ctrl_type;

   typedef struct packed {
      logic     capture;
      logic     step;
      logic     load_rsp;
      ctrl_type uc;
   } dp_ctrl_type;

   localparam logic signed [SUM_WIDTH-1:0] COORD_HI =
      $signed((SUM_WIDTH'(1) << (COORD_WIDTH - 1)) - SUM_WIDTH'(1));
   localparam logic signed [SUM_WIDTH-1:0] COORD_LO = -COORD_HI - $signed(SUM_WIDTH'(1));

   function automatic logic signed [SUM_WIDTH-1:0] ext_word(
      input logic signed [WORD_WIDTH-1:0] w);
      return {{(SUM_WIDTH - WORD_WIDTH){w[WORD_WIDTH-1]}}, w};
   endfunction

   function automatic logic signed [WORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] r;
      if (v > COORD_HI) begin
         r = COORD_HI;
      end else if (v < COORD_LO) begin
         r = COORD_LO;
      end else begin
         r = v;
      end
      return r[WORD_WIDTH-1:0];
   endfunction

endpackage

FILE: rtl/path_bounds_and_hash.sv
// Top level of the path bounds and hash block.
// Depends on pbh_pkg, pbh_ucode, pbh_seq and pbh_dp.
//
// Usage:
//   Request channel (req_*): one path command per word, with its code, winding
//   and eight Q16.16 data words. A word is taken when req_valid is high and
//   req_stall is low. Response channel (rsp_*): one word per command with the
//   running bounding box, the 64-bit content hash and the empty flag.
//   A microcoded sequencer runs one program step per cycle; the hash unit folds
//   at most one value per step (code, winding, then each data word the code counts)
//   and the box unit takes at most one bound point per step.
//   A command's program runs the code step, the winding step, then one step per
//   data word (one empty step for set_winding and close); clear runs a single
//   clearing step and codes twelve to fifteen a single empty step. A new command
//   can be taken from the cycle after the response is loaded.
//   Reset is synchronous, active high: the box clears to zero, the hash returns
//   to the FNV offset basis and no command is counted as seen; no response is pending.
//   When rsp_stall holds a response, the response register keeps its word and
//   the next command finishes its program and waits for the register to free.
module path_bounds_and_hash
   import pbh_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CODE_WIDTH-1:0]        req_command,
   input  logic                         req_winding,
   input  logic signed [WORD_WIDTH-1:0] req_word0,
   input  logic signed [WORD_WIDTH-1:0] req_word1,
   input  logic signed [WORD_WIDTH-1:0] req_word2,
   input  logic signed [WORD_WIDTH-1:0] req_word3,
   input  logic signed [WORD_WIDTH-1:0] req_word4,
   input  logic signed [WORD_WIDTH-1:0] req_word5,
   input  logic signed [WORD_WIDTH-1:0] req_word6,
   input  logic signed [WORD_WIDTH-1:0] req_word7,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_WIDTH-1:0] rsp_box_x,
   output logic signed [WORD_WIDTH-1:0] rsp_box_y,
   output logic [WORD_WIDTH-1:0]        rsp_box_width,
   output logic [WORD_WIDTH-1:0]        rsp_box_height,
   output logic [HASH_WIDTH-1:0]        rsp_content_hash,
   output logic                         rsp_is_empty
);

   pc_type      pc;
   ctrl_type    ctrl;
   dp_ctrl_type dc;

   pbh_ucode u_ucode (
      .pc   (pc),
      .ctrl (ctrl)
   );

   pbh_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .ctrl        (ctrl),
      .pc          (pc),
      .dc          (dc)
   );

   pbh_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dc               (dc),
      .req_command      (req_command),
      .req_winding      (req_winding),
      .req_word0        (req_word0),
      .req_word1        (req_word1),
      .req_word2        (req_word2),
      .req_word3        (req_word3),
      .req_word4        (req_word4),
      .req_word5        (req_word5),
      .req_word6        (req_word6),
      .req_word7        (req_word7),
      .rsp_box_x        (rsp_box_x),
      .rsp_box_y        (rsp_box_y),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .rsp_content_hash (rsp_content_hash),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule

FILE: rtl/pbh_ucode.sv
// Control store: one control word per program step, addressed by the step counter.
// Depends on pbh_pkg for the control word layout and program addresses.
module pbh_ucode
   import pbh_pkg::*;
(
   input  pc_type   pc,
   output ctrl_type ctrl
);

   function automatic ctrl_type cw(input hash_src_type hs, input logic [2:0] ws,
                                   input pt_op_type pt, input logic mk,
                                   input logic cl, input next_type nx);
      ctrl_type c;
      c.hash_src = hs;
      c.word_sel = ws;
      c.pt_op    = pt;
      c.mark     = mk;
      c.clear    = cl;
      c.next     = nx;
      return c;
   endfunction

   always_comb begin
      case (pc)
         // common prefix
         6'd0:  ctrl = cw(HS_CODE, 3'd0, PT_NONE, 1'b1, 1'b0, NX_SEQ);
         6'd1:  ctrl = cw(HS_WIND, 3'd0, PT_NONE, 1'b0, 1'b0, NX_BODY);
         // set_winding, close
         6'd2:  ctrl = cw(HS_NONE, 3'd0, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // move, line
         6'd3:  ctrl = cw(HS_WORD, 3'd0, PT_W01,  1'b0, 1'b0, NX_SEQ);
         6'd4:  ctrl = cw(HS_WORD, 3'd1, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // quad
         6'd5:  ctrl = cw(HS_WORD, 3'd0, PT_W01,  1'b0, 1'b0, NX_SEQ);
         6'd6:  ctrl = cw(HS_WORD, 3'd1, PT_W23,  1'b0, 1'b0, NX_SEQ);
         6'd7:  ctrl = cw(HS_WORD, 3'd2, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd8:  ctrl = cw(HS_WORD, 3'd3, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // bezier
         6'd9:  ctrl = cw(HS_WORD, 3'd0, PT_W01,  1'b0, 1'b0, NX_SEQ);
         6'd10: ctrl = cw(HS_WORD, 3'd1, PT_W23,  1'b0, 1'b0, NX_SEQ);
         6'd11: ctrl = cw(HS_WORD, 3'd2, PT_W45,  1'b0, 1'b0, NX_SEQ);
         6'd12: ctrl = cw(HS_WORD, 3'd3, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd13: ctrl = cw(HS_WORD, 3'd4, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd14: ctrl = cw(HS_WORD, 3'd5, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // arc_to
         6'd15: ctrl = cw(HS_WORD, 3'd0, PT_W01,  1'b0, 1'b0, NX_SEQ);
         6'd16: ctrl = cw(HS_WORD, 3'd1, PT_W23,  1'b0, 1'b0, NX_SEQ);
         6'd17: ctrl = cw(HS_WORD, 3'd2, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd18: ctrl = cw(HS_WORD, 3'd3, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd19: ctrl = cw(HS_WORD, 3'd4, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // arc
         6'd20: ctrl = cw(HS_WORD, 3'd0, PT_CLO,  1'b0, 1'b0, NX_SEQ);
         6'd21: ctrl = cw(HS_WORD, 3'd1, PT_CHI,  1'b0, 1'b0, NX_SEQ);
         6'd22: ctrl = cw(HS_WORD, 3'd2, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd23: ctrl = cw(HS_WORD, 3'd3, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd24: ctrl = cw(HS_WORD, 3'd4, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd25: ctrl = cw(HS_WORD, 3'd5, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // rect
         6'd26: ctrl = cw(HS_WORD, 3'd0, PT_W01,  1'b0, 1'b0, NX_SEQ);
         6'd27: ctrl = cw(HS_WORD, 3'd1, PT_SUM,  1'b0, 1'b0, NX_SEQ);
         6'd28: ctrl = cw(HS_WORD, 3'd2, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd29: ctrl = cw(HS_WORD, 3'd3, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd30: ctrl = cw(HS_WORD, 3'd4, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd31: ctrl = cw(HS_WORD, 3'd5, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd32: ctrl = cw(HS_WORD, 3'd6, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd33: ctrl = cw(HS_WORD, 3'd7, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // circle
         6'd34: ctrl = cw(HS_WORD, 3'd0, PT_CLO,  1'b0, 1'b0, NX_SEQ);
         6'd35: ctrl = cw(HS_WORD, 3'd1, PT_CHI,  1'b0, 1'b0, NX_SEQ);
         6'd36: ctrl = cw(HS_WORD, 3'd2, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // ellipse
         6'd37: ctrl = cw(HS_WORD, 3'd0, PT_ELO,  1'b0, 1'b0, NX_SEQ);
         6'd38: ctrl = cw(HS_WORD, 3'd1, PT_SUM,  1'b0, 1'b0, NX_SEQ);
         6'd39: ctrl = cw(HS_WORD, 3'd2, PT_NONE, 1'b0, 1'b0, NX_SEQ);
         6'd40: ctrl = cw(HS_WORD, 3'd3, PT_NONE, 1'b0, 1'b0, NX_DONE);
         // clear
         6'd41: ctrl = cw(HS_NONE, 3'd0, PT_NONE, 1'b0, 1'b1, NX_DONE);
         default: ctrl = cw(HS_NONE, 3'd0, PT_NONE, 1'b0, 1'b0, NX_DONE);
      endcase
   end

endmodule

FILE: rtl/pbh_seq.sv
// Sequencer: step counter, dispatch jumps and the request/response handshake.
// Depends on pbh_pkg; reads control words from pbh_ucode, drives pbh_dp.
module pbh_seq
   import pbh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  code_type    req_command,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  ctrl_type    ctrl,
   output pc_type      pc,
   output dp_ctrl_type dc
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   pc_type    pc_ff, pc_in;
   code_type  code_ff, code_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load;

   function automatic pc_type entry_addr(input code_type c);
      pc_type a;
      if (c == CMD_CLEAR) begin
         a = A_CLEAR;
      end else if (c > CMD_CLEAR) begin
         a = A_NOP;
      end else begin
         a = A_CODE;
      end
      return a;
   endfunction

   function automatic pc_type body_addr(input code_type c);
      pc_type a;
      case (c)
         CMD_SET_WINDING: a = A_NOWORDS;
         CMD_MOVE:        a = A_LINE;
         CMD_LINE:        a = A_LINE;
         CMD_QUAD:        a = A_QUAD;
         CMD_BEZIER:      a = A_BEZIER;
         CMD_ARC_TO:      a = A_ARC_TO;
         CMD_ARC:         a = A_ARC;
         CMD_RECT:        a = A_RECT;
         CMD_CIRCLE:      a = A_CIRCLE;
         CMD_ELLIPSE:     a = A_ELLIPSE;
         CMD_CLOSE:       a = A_NOWORDS;
         default:         a = A_NOP;
      endcase
      return a;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign load      = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign pc        = pc_ff;

   always_comb begin
      dc.capture  = accept;
      dc.step     = (state_ff == S_RUN);
      dc.load_rsp = load;
      dc.uc       = ctrl;
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      code_in      = code_ff;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pc_in    = entry_addr(req_command);
               code_in  = req_command;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            case (ctrl.next)
               NX_SEQ:  pc_in = pc_ff + pc_type'(1);
               NX_BODY: pc_in = body_addr(code_ff);
               default: state_in = S_EMIT;
            endcase
         end
         S_EMIT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= A_CODE;
         code_ff      <= CMD_SET_WINDING;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/pbh_dp.sv
// Datapath: latched words, hash combine unit, box compare unit and response register.
// Depends on pbh_pkg; controlled by pbh_seq through dp_ctrl_type.
module pbh_dp
   import pbh_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  dp_ctrl_type                  dc,
   input  code_type                     req_command,
   input  logic                         req_winding,
   input  logic signed [WORD_WIDTH-1:0] req_word0,
   input  logic signed [WORD_WIDTH-1:0] req_word1,
   input  logic signed [WORD_WIDTH-1:0] req_word2,
   input  logic signed [WORD_WIDTH-1:0] req_word3,
   input  logic signed [WORD_WIDTH-1:0] req_word4,
   input  logic signed [WORD_WIDTH-1:0] req_word5,
   input  logic signed [WORD_WIDTH-1:0] req_word6,
   input  logic signed [WORD_WIDTH-1:0] req_word7,
   output logic signed [WORD_WIDTH-1:0] rsp_box_x,
   output logic signed [WORD_WIDTH-1:0] rsp_box_y,
   output logic [WORD_WIDTH-1:0]        rsp_box_width,
   output logic [WORD_WIDTH-1:0]        rsp_box_height,
   output logic [HASH_WIDTH-1:0]        rsp_content_hash,
   output logic                         rsp_is_empty
);

   logic signed [WORD_WIDTH-1:0] req_words [WORD_COUNT];
   logic [WORD_WIDTH-1:0]        raw_ff [WORD_COUNT];
   logic signed [WORD_WIDTH-1:0] sat_ff [POINT_WORDS];
   code_type                     code_ff;
   logic                         wind_ff;

   logic signed [WORD_WIDTH-1:0] least_x_ff, least_x_in, least_y_ff, least_y_in;
   logic signed [WORD_WIDTH-1:0] most_x_ff, most_x_in, most_y_ff, most_y_in;
   logic                         has_point_ff, has_point_in;
   logic                         has_cmd_ff, has_cmd_in;
   logic [HASH_WIDTH-1:0]        hash_ff, hash_in;

   logic signed [WORD_WIDTH-1:0] box_x_ff, box_y_ff;
   logic [WORD_WIDTH-1:0]        box_w_ff, box_h_ff;
   logic [HASH_WIDTH-1:0]        rsp_hash_ff;
   logic                         rsp_empty_ff;

   logic [HASH_WIDTH-1:0]        hash_val;
   logic signed [SUM_WIDTH-1:0]  px_wide, py_wide;
   logic signed [WORD_WIDTH-1:0] px, py;

   always_comb begin
      req_words[0] = req_word0;
      req_words[1] = req_word1;
      req_words[2] = req_word2;
      req_words[3] = req_word3;
      req_words[4] = req_word4;
      req_words[5] = req_word5;
      req_words[6] = req_word6;
      req_words[7] = req_word7;
   end

   always_comb begin
      case (dc.uc.hash_src)
         HS_CODE: hash_val = HASH_WIDTH'(code_ff);
         HS_WIND: hash_val = HASH_WIDTH'(wind_ff);
         HS_WORD: hash_val = HASH_WIDTH'(raw_ff[dc.uc.word_sel]);
         default: hash_val = '0;
      endcase
   end

   always_comb begin
      case (dc.uc.pt_op)
         PT_W01: begin
            px_wide = ext_word(sat_ff[0]);
            py_wide = ext_word(sat_ff[1]);
         end
         PT_W23: begin
            px_wide = ext_word(sat_ff[2]);
            py_wide = ext_word(sat_ff[3]);
         end
         PT_W45: begin
            px_wide = ext_word(sat_ff[4]);
            py_wide = ext_word(sat_ff[5]);
         end
         PT_CLO: begin
            px_wide = ext_word(sat_ff[0]) - ext_word(sat_ff[2]);
            py_wide = ext_word(sat_ff[1]) - ext_word(sat_ff[2]);
         end
         PT_CHI: begin
            px_wide = ext_word(sat_ff[0]) + ext_word(sat_ff[2]);
            py_wide = ext_word(sat_ff[1]) + ext_word(sat_ff[2]);
         end
         PT_SUM: begin
            px_wide = ext_word(sat_ff[0]) + ext_word(sat_ff[2]);
            py_wide = ext_word(sat_ff[1]) + ext_word(sat_ff[3]);
         end
         PT_ELO: begin
            px_wide = ext_word(sat_ff[0]) - ext_word(sat_ff[2]);
            py_wide = ext_word(sat_ff[1]) - ext_word(sat_ff[3]);
         end
         default: begin
            px_wide = '0;
            py_wide = '0;
         end
      endcase
      px = sat_coord(px_wide);
      py = sat_coord(py_wide);
   end

   always_comb begin
      least_x_in   = least_x_ff;
      least_y_in   = least_y_ff;
      most_x_in    = most_x_ff;
      most_y_in    = most_y_ff;
      has_point_in = has_point_ff;
      has_cmd_in   = has_cmd_ff;
      hash_in      = hash_ff;
      if (dc.step) begin
         if (dc.uc.clear) begin
            least_x_in   = '0;
            least_y_in   = '0;
            most_x_in    = '0;
            most_y_in    = '0;
            has_point_in = 1'b0;
            has_cmd_in   = 1'b0;
            hash_in      = FNV_BASIS;
         end else begin
            if (dc.uc.mark) begin
               has_cmd_in = 1'b1;
            end
            if (dc.uc.hash_src != HS_NONE) begin
               hash_in = hash_ff ^ (hash_val + GOLDEN_K + (hash_ff << 6) + (hash_ff >> 2));
            end
            if (dc.uc.pt_op != PT_NONE) begin
               has_point_in = 1'b1;
               if (!has_point_ff) begin
                  least_x_in = px;
                  most_x_in  = px;
                  least_y_in = py;
                  most_y_in  = py;
               end else begin
                  if (px < least_x_ff) least_x_in = px;
                  if (px > most_x_ff)  most_x_in  = px;
                  if (py < least_y_ff) least_y_in = py;
                  if (py > most_y_ff)  most_y_in  = py;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         least_x_ff   <= '0;
         least_y_ff   <= '0;
         most_x_ff    <= '0;
         most_y_ff    <= '0;
         has_point_ff <= 1'b0;
         has_cmd_ff   <= 1'b0;
         hash_ff      <= FNV_BASIS;
      end else begin
         least_x_ff   <= least_x_in;
         least_y_ff   <= least_y_in;
         most_x_ff    <= most_x_in;
         most_y_ff    <= most_y_in;
         has_point_ff <= has_point_in;
         has_cmd_ff   <= has_cmd_in;
         hash_ff      <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dc.capture) begin
         code_ff <= req_command;
         wind_ff <= req_winding;
         for (int i = 0; i < WORD_COUNT; i++) begin
            raw_ff[i] <= req_words[i];
         end
         for (int i = 0; i < POINT_WORDS; i++) begin
            sat_ff[i] <= sat_coord(ext_word(req_words[i]));
         end
      end
      if (dc.load_rsp) begin
         if (has_point_ff) begin
            box_x_ff <= least_x_ff;
            box_y_ff <= least_y_ff;
            box_w_ff <= most_x_ff - least_x_ff;
            box_h_ff <= most_y_ff - least_y_ff;
         end else begin
            box_x_ff <= '0;
            box_y_ff <= '0;
            box_w_ff <= '0;
            box_h_ff <= '0;
         end
         rsp_hash_ff  <= hash_ff;
         rsp_empty_ff <= !has_cmd_ff;
      end
   end

   assign rsp_box_x        = box_x_ff;
   assign rsp_box_y        = box_y_ff;
   assign rsp_box_width    = box_w_ff;
   assign rsp_box_height   = box_h_ff;
   assign rsp_content_hash = rsp_hash_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

FILE: rtl/pbh_checker.sv
// Port-level checker for path_bounds_and_hash, attached by a bind statement.
// Depends on pbh_pkg for field widths and the hash seed.
module pbh_props
   import pbh_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [WORD_WIDTH-1:0] rsp_box_x,
   input logic signed [WORD_WIDTH-1:0] rsp_box_y,
   input logic [WORD_WIDTH-1:0]        rsp_box_width,
   input logic [WORD_WIDTH-1:0]        rsp_box_height,
   input logic [HASH_WIDTH-1:0]        rsp_content_hash,
   input logic                         rsp_is_empty
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !(rsp_valid && !$past(rsp_valid)))
      else $error("request side not busy after accept");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_box_x == '0 && rsp_box_y == '0 &&
         rsp_box_width == '0 && rsp_box_height == '0)
      else $error("empty response with nonzero box");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_content_hash == FNV_BASIS)
      else $error("empty response with hash off its seed");

endmodule

bind path_bounds_and_hash pbh_props u_pbh_checker (.*);
